// ===== design/lut_segment_ramp_fill_defines.svh =====
// ----------------------------------------------------------------------------
// lut_segment_ramp_fill assertion macros
// shared concurrent assertion forms, sampled on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef LUT_SEGMENT_RAMP_FILL_DEFINES_SVH
`define LUT_SEGMENT_RAMP_FILL_DEFINES_SVH

// same-cycle implication
`define LSRF_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define LSRF_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== design/lsrf_pkg.sv =====
// ----------------------------------------------------------------------------
// lsrf_pkg
// shared constants, state encoding and controller/datapath bundles
// ----------------------------------------------------------------------------
package lsrf_pkg;

    localparam int LUT_DEPTH  = 4096;
    localparam int LUT_AW     = $clog2(LUT_DEPTH);
    localparam int X_W        = 16;
    localparam int Y_W        = 8;
    localparam int ADDR_W     = 12;
    localparam int COUNT_W    = 13;
    // divisor is 2*dx
    localparam int DEN_W      = X_W + 1;
    // dividend is |2*dy|
    localparam int NUM_W      = Y_W + 1;
    localparam int DIV_STEPS  = NUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int Q_W        = Y_W + 2;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 24;

    typedef enum logic
    {
        CMD_FILL = 1'b0,
        CMD_READ = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_RAMP,
        S_READ,
        S_RESULT
    } state_t;

    typedef struct packed
    {
        logic capture;
        logic div_init;
        logic ramp_init;
        logic div_step;
        logic ramp_step;
        logic mem_rd;
        logic out_load;
    } ctl_t;

    typedef struct packed
    {
        logic empty;
        logic div_last;
        logic ramp_last;
        logic out_free;
    } sts_t;

endpackage

// ===== design/lsrf_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsrf_ctrl
// sequencer for fill and read items: setup, divide, ramp walk or table read, result
// ----------------------------------------------------------------------------
`include "lut_segment_ramp_fill_defines.svh"

module lsrf_ctrl
    import lsrf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_valid,
    input  logic s_kind,
    output logic s_ready,
    input  sts_t sts,
    output ctl_t ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = (op_t'(s_kind) == CMD_READ) ? S_READ : S_PREP;
                end
            end
            S_PREP:
            begin
                if (sts.empty)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    ctl.div_init  = 1'b1;
                    ctl.ramp_init = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_RAMP;
                end
            end
            S_RAMP:
            begin
                ctl.ramp_step = 1'b1;
                if (sts.ramp_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_READ:
            begin
                ctl.mem_rd = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `LSRF_ASSERT_IMP(a_ctl_onehot, 1'b1, $onehot0({ctl.capture, ctl.div_step, ctl.ramp_step, ctl.mem_rd, ctl.out_load}), "more than one datapath command")
    `LSRF_ASSERT_NXT(a_ramp_stays, state_reg == S_RAMP && !sts.ramp_last, state_reg == S_RAMP, "ramp walk left early")
    `LSRF_ASSERT_NXT(a_empty_skip, state_reg == S_PREP && sts.empty, state_reg == S_RESULT, "empty fill did not go to result")

endmodule

// ===== design/lsrf_datapath.sv =====
// ----------------------------------------------------------------------------
// lsrf_datapath
// item registers, slope divider, ramp stepper, table memory, result register
// ----------------------------------------------------------------------------
`include "lut_segment_ramp_fill_defines.svh"

module lsrf_datapath
    import lsrf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctl_t                 ctl,
    output sts_t                 sts,
    input  logic [S_TDATA_W-1:0] s_data,
    input  logic                 s_kind,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [M_TDATA_W-1:0] m_data
);

    function automatic logic [LUT_AW-1:0] clip_index(input logic [X_W-1:0] x);
        logic [LUT_AW-1:0] res;
        if (32'(x) > LUT_DEPTH - 1)
        begin
            res = LUT_AW'(LUT_DEPTH - 1);
        end
        else
        begin
            res = LUT_AW'(x);
        end
        return res;
    endfunction

    // captured item
    op_t               op_reg;
    logic [X_W-1:0]    xs_reg;
    logic [Y_W-1:0]    ys_reg;
    logic [X_W-1:0]    xe_reg;
    logic [Y_W-1:0]    ye_reg;
    logic [ADDR_W-1:0] addr_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            op_reg   <= op_t'(s_kind);
            xs_reg   <= s_data[X_W-1:0];
            ys_reg   <= s_data[X_W +: Y_W];
            xe_reg   <= s_data[X_W+Y_W +: X_W];
            ye_reg   <= s_data[2*X_W+Y_W +: Y_W];
            addr_reg <= s_data[2*X_W+2*Y_W +: ADDR_W];
        end
    end

    // ordered end points and segment geometry
    logic                swap;
    logic [X_W-1:0]      x0;
    logic [X_W-1:0]      x1;
    logic [Y_W-1:0]      y0;
    logic [Y_W-1:0]      y1;
    logic [X_W-1:0]      dx;
    logic signed [Y_W:0] dy;
    logic                dy_neg;
    logic [Y_W-1:0]      dy_mag;
    logic [NUM_W-1:0]    two_dy_mag;
    logic [DEN_W-1:0]    den;
    logic [LUT_AW-1:0]   c0;
    logic [LUT_AW-1:0]   c1;
    logic                empty;
    logic [COUNT_W-1:0]  count;

    always_comb
    begin
        swap       = xs_reg > xe_reg;
        x0         = swap ? xe_reg : xs_reg;
        x1         = swap ? xs_reg : xe_reg;
        y0         = swap ? ye_reg : ys_reg;
        y1         = swap ? ys_reg : ye_reg;
        dx         = x1 - x0;
        dy         = $signed({1'b0, y1}) - $signed({1'b0, y0});
        dy_neg     = dy[Y_W];
        dy_mag     = dy_neg ? Y_W'(-dy) : Y_W'(dy);
        two_dy_mag = {dy_mag, 1'b0};
        den        = {dx, 1'b0};
        c0         = clip_index(x0);
        c1         = clip_index(x1);
        empty      = (xs_reg == xe_reg) || (c0 == c1);
        count      = COUNT_W'(c1) - COUNT_W'(c0) + COUNT_W'(1);
    end

    // restoring divider: |2*dy| / (2*dx), one quotient bit a cycle
    logic [NUM_W-1:0]     numq_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DEN_W:0]       trial;
    logic                 fits;

    assign trial = {rem_reg, numq_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (ctl.div_init)
        begin
            div_cnt_reg <= '0;
        end
        else if (ctl.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.div_init)
        begin
            numq_reg <= two_dy_mag;
            rem_reg  <= '0;
        end
        else if (ctl.div_step)
        begin
            numq_reg <= {numq_reg[NUM_W-2:0], fits};
            rem_reg  <= fits ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
        end
    end

    // floored step: 2*dy = sq*den + sr with 0 <= sr < den
    logic                  rem_zero;
    logic signed [Q_W-1:0] q_mag;
    logic signed [Q_W-1:0] sq;
    logic [DEN_W-1:0]      sr;

    always_comb
    begin
        rem_zero = rem_reg == '0;
        q_mag    = $signed({1'b0, numq_reg});
        if (!dy_neg)
        begin
            sq = q_mag;
            sr = rem_reg;
        end
        else if (rem_zero)
        begin
            sq = -q_mag;
            sr = '0;
        end
        else
        begin
            sq = -q_mag - Q_W'(1);
            sr = den - rem_reg;
        end
    end

    // ramp stepper: value and remainder of (2*y0*dx + dx + 2*k*dy) / (2*dx)
    logic [LUT_AW-1:0]     x_reg;
    logic signed [Q_W-1:0] q_reg;
    logic [DEN_W-1:0]      r_reg;
    logic [DEN_W:0]        r_sum;
    logic                  wrap;

    assign r_sum = {1'b0, r_reg} + {1'b0, sr};
    assign wrap  = r_sum >= {1'b0, den};

    always_ff @(posedge clk)
    begin
        if (ctl.ramp_init)
        begin
            x_reg <= c0;
            q_reg <= $signed(Q_W'(y0));
            r_reg <= DEN_W'(dx);
        end
        else if (ctl.ramp_step)
        begin
            x_reg <= x_reg + LUT_AW'(1);
            q_reg <= q_reg + sq + (wrap ? Q_W'(1) : Q_W'(0));
            r_reg <= wrap ? DEN_W'(r_sum - {1'b0, den}) : DEN_W'(r_sum);
        end
    end

    // table memory, one write or one read a cycle
    logic [Y_W-1:0] table_mem [LUT_DEPTH];
    logic [Y_W-1:0] rd_data_reg;
    logic           rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.ramp_step)
        begin
            table_mem[x_reg] <= q_reg[Y_W-1:0];
        end
        if (ctl.mem_rd)
        begin
            rd_data_reg <= table_mem[LUT_AW'(addr_reg)];
            rd_hit_reg  <= 32'(addr_reg) < LUT_DEPTH;
        end
    end

    // result register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [Y_W-1:0]       res_value;
    logic [COUNT_W-1:0]   res_count;
    logic                 out_free;

    assign out_free  = !out_valid_reg || m_ready;
    assign res_value = (op_reg == CMD_READ && rd_hit_reg) ? rd_data_reg : '0;
    assign res_count = (op_reg == CMD_FILL && !empty) ? count : '0;

    always_comb
    begin
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_data_reg <= {(M_TDATA_W-COUNT_W-Y_W)'(0), res_count, res_value};
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_data        = out_data_reg;
    assign sts.empty     = empty;
    assign sts.div_last  = div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);
    assign sts.ramp_last = x_reg == c1;
    assign sts.out_free  = out_free;

    `LSRF_ASSERT_IMP(a_no_overwrite, ctl.out_load, out_free, "result loaded over a pending beat")
    `LSRF_ASSERT_IMP(a_ramp_range, ctl.ramp_step, q_reg >= 0 && q_reg <= 255, "ramp value out of range")
    `LSRF_ASSERT_IMP(a_rem_bound, ctl.ramp_step, r_reg < den, "ramp remainder not below divisor")

endmodule

// ===== design/lut_segment_ramp_fill.sv =====
// ----------------------------------------------------------------------------
// lut_segment_ramp_fill
// display transfer table of 4096 8-bit entries with segment ramp fill
// ----------------------------------------------------------------------------
// input beats on s_axis: tuser selects fill (0) or read (1); a fill writes a
// straight line between two end points, rounded half up, clipped to the table;
// a read returns one entry. every input beat gives exactly one output beat on
// m_axis with read_value and written_count.
// one item at a time: s_axis_tready is high only while the sequencer is idle.
// read: the memory read, then the result load into the output register.
// fill: the setup step, the 9-step slope divider and the ramp walk writing one
// entry per cycle through the single memory port, then the result load; a fill
// that writes nothing goes from setup straight to the result load.
// the output register holds a finished beat while m_axis_tready is low; the
// next item is accepted meanwhile and waits for the register before loading.
// reset clears the sequencer and the output valid; table contents are left
// as they are and an entry reads as undefined until it has been filled.
// ----------------------------------------------------------------------------
module lut_segment_ramp_fill
    import lsrf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // seg_x_start, seg_y_start, seg_x_end, seg_y_end, read_addr, zero pad
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // cmd
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // read_value, written_count, zero pad
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    ctl_t ctl;
    sts_t sts;

    lsrf_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_kind  (s_axis_tuser),
        .s_ready (s_axis_tready),
        .sts     (sts),
        .ctl     (ctl)
    );

    lsrf_datapath u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .sts     (sts),
        .s_data  (s_axis_tdata),
        .s_kind  (s_axis_tuser),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_data  (m_axis_tdata)
    );

endmodule

// ===== sim/lut_segment_ramp_fill_tb.sv =====
// ----------------------------------------------------------------------------
// lut_segment_ramp_fill_tb
// self-checking bench for the segment ramp fill transfer table
// ----------------------------------------------------------------------------
// items are queued up front and fed over s_axis with random gaps. a shadow
// copy of the table is updated by every accepted fill and gives the expected
// output of every item, which the monitor checks field by field against m_axis. the
// first item fills the whole table so that no read ever hits an unwritten
// entry. the receiver stalls at random and once holds off for a long stretch
// so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module lut_segment_ramp_fill_tb;

    import lsrf_pkg::*;

    localparam int QUIET_LIMIT = 20000;
    localparam int CALM_TAIL   = 25;
    localparam int LONG_HOLD   = 250;
    localparam int HOLD_AFTER  = 40;
    localparam int RANDOM_ITEMS = 120;

    typedef struct {
        op_t             cmd;
        logic [X_W-1:0]  x_start;
        logic [Y_W-1:0]  y_start;
        logic [X_W-1:0]  x_end;
        logic [Y_W-1:0]  y_end;
        logic [ADDR_W-1:0] addr;
    } ramp_item_t;

    typedef struct {
        logic [Y_W-1:0]     read_value;
        logic [COUNT_W-1:0] written_count;
    } lut_beat_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    ramp_item_t pending[$];
    lut_beat_t  expected_beats[$];
    logic [Y_W-1:0] shadow_lut [LUT_DEPTH];

    logic in_taken = 1'b0;
    int   in_gap = 0;
    int   out_gap = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;
    int   n_total = 0;
    int   out_count = 0;
    int   quiet_cycles = 0;
    int   fail_count = 0;
    int   fills_seen = 0;
    int   reads_seen = 0;
    int   empty_fills = 0;
    int   cells_written = 0;

    lut_segment_ramp_fill DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // applies one item to the shadow table and returns the beat it should give
    function automatic lut_beat_t shadow_table_step(input ramp_item_t it);
        lut_beat_t r;
        longint x0, y0, x1, y1, dx, dy, c0, c1, num, v;
        longint x;
        r.read_value    = '0;
        r.written_count = '0;
        if (it.cmd == CMD_READ)
        begin
            r.read_value = shadow_lut[it.addr];
        end
        else if (it.x_start != it.x_end)
        begin
            if (it.x_start < it.x_end)
            begin
                x0 = it.x_start; y0 = it.y_start;
                x1 = it.x_end;   y1 = it.y_end;
            end
            else
            begin
                x0 = it.x_end;   y0 = it.y_end;
                x1 = it.x_start; y1 = it.y_start;
            end
            // slope from the unclipped points
            dx = x1 - x0;
            dy = y1 - y0;
            c0 = (x0 > LUT_DEPTH - 1) ? LUT_DEPTH - 1 : x0;
            c1 = (x1 > LUT_DEPTH - 1) ? LUT_DEPTH - 1 : x1;
            if (c0 != c1)
            begin
                for (x = c0; x <= c1; x++)
                begin
                    // round half up: floor(y0 + (x-c0)*dy/dx + 1/2)
                    num = 2 * y0 * dx + 2 * (x - c0) * dy + dx;
                    v = (num > 0) ? num / (2 * dx) : 0;
                    if (v > 255)
                        v = 255;
                    shadow_lut[x] = v[Y_W-1:0];
                end
                r.written_count = COUNT_W'(c1 - c0 + 1);
            end
        end
        return r;
    endfunction

    task automatic queue_fill(input logic [X_W-1:0] xs, input logic [Y_W-1:0] ys,
                              input logic [X_W-1:0] xe, input logic [Y_W-1:0] ye);
        ramp_item_t it;
        it.cmd     = CMD_FILL;
        it.x_start = xs;
        it.y_start = ys;
        it.x_end   = xe;
        it.y_end   = ye;
        it.addr    = ADDR_W'($urandom);
        pending.push_back(it);
    endtask

    // seg fields are ignored on a read but still get random content
    task automatic queue_read(input logic [ADDR_W-1:0] a);
        ramp_item_t it;
        it.cmd     = CMD_READ;
        it.x_start = X_W'($urandom);
        it.y_start = Y_W'($urandom);
        it.x_end   = X_W'($urandom);
        it.y_end   = Y_W'($urandom);
        it.addr    = a;
        pending.push_back(it);
    endtask

    // input side: hold a beat until taken, gaps only between beats
    always @(negedge clk)
    begin : feed_items
        ramp_item_t it;
        if (rst_n)
        begin
            if (in_taken)
                pending.pop_front();
            if (!(s_axis_tvalid && !in_taken))
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending.size() > CALM_TAIL && $urandom_range(0, 3) == 0)
                begin
                    in_gap = $urandom_range(0, 2);
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    it = pending[0];
                    s_axis_tdata  <= S_TDATA_W'({it.addr, it.y_end, it.x_end,
                                                 it.y_start, it.x_start});
                    s_axis_tuser  <= it.cmd;
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: random stalls plus one long hold-off
    always @(negedge clk)
    begin : pace_results
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!hold_done && out_count >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end
            else if (out_gap > 0)
            begin
                out_gap--;
                m_axis_tready <= 1'b0;
            end
            else if (out_count < n_total - CALM_TAIL && $urandom_range(0, 3) == 0)
            begin
                out_gap = $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : watch_ports
        ramp_item_t it;
        lut_beat_t  got;
        lut_beat_t  want;
        if (rst_n)
        begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            // check outputs before recording this edge's input beat
            if (m_axis_tvalid && m_axis_tready)
            begin
                out_count++;
                got.read_value    = m_axis_tdata[Y_W-1:0];
                got.written_count = m_axis_tdata[Y_W +: COUNT_W];
                if (expected_beats.size() == 0)
                begin
                    $error("unexpected output beat: read_value %0d, written_count %0d",
                           got.read_value, got.written_count);
                    fail_count++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (got.read_value !== want.read_value)
                    begin
                        $error("read_value: expected %0d, actual %0d",
                               want.read_value, got.read_value);
                        fail_count++;
                    end
                    if (got.written_count !== want.written_count)
                    begin
                        $error("written_count: expected %0d, actual %0d",
                               want.written_count, got.written_count);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                it.cmd     = op_t'(s_axis_tuser);
                it.x_start = s_axis_tdata[15:0];
                it.y_start = s_axis_tdata[23:16];
                it.x_end   = s_axis_tdata[39:24];
                it.y_end   = s_axis_tdata[47:40];
                it.addr    = s_axis_tdata[59:48];
                want = shadow_table_step(it);
                expected_beats.push_back(want);
                if (it.cmd == CMD_READ)
                    reads_seen++;
                else
                begin
                    fills_seen++;
                    cells_written += want.written_count;
                    if (want.written_count == 0)
                        empty_fills++;
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         QUIET_LIMIT, expected_beats.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin : run_test
        int i;
        int pick;
        int last_x;
        logic [X_W-1:0] xa;
        logic [X_W-1:0] xb;
        logic [X_W-1:0] tmp;

        // whole table first, so every later read hits a written entry
        queue_fill(16'd0, 8'd0, 16'd4095, 8'd255);
        queue_read(12'd0);
        queue_read(12'd2048);
        queue_read(12'd4095);
        // end points given falling in x
        queue_fill(16'd100, 8'd200, 16'd40, 8'd10);
        queue_read(12'd40);
        queue_read(12'd70);
        queue_read(12'd100);
        // equal x writes nothing
        queue_fill(16'd300, 8'd5, 16'd300, 8'd250);
        queue_read(12'd300);
        // both ends past the last entry, then one on it
        queue_fill(16'd5000, 8'd1, 16'd6000, 8'd2);
        queue_fill(16'd4095, 8'd9, 16'd65535, 8'd77);
        // upper end clipped, slope kept from the far point
        queue_fill(16'd4000, 8'd255, 16'd65535, 8'd0);
        queue_read(12'd4000);
        queue_read(12'd4095);
        // steepest step over one entry
        queue_fill(16'd10, 8'd0, 16'd11, 8'd255);
        queue_read(12'd10);
        queue_read(12'd11);
        // full x range, swapped
        queue_fill(16'd65535, 8'd255, 16'd0, 8'd0);
        queue_read(12'd4095);
        queue_read(12'd1);

        last_x = 0;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 99) < 35)
            begin
                pick = $urandom_range(0, 99);
                xa = X_W'($urandom_range(0, LUT_DEPTH - 1));
                xb = xa + X_W'($urandom_range(1, 40));
                if (pick >= 70 && pick < 80)
                    xb = xa;
                else if (pick >= 80 && pick < 88)
                begin
                    xa = X_W'(LUT_DEPTH - 1 - $urandom_range(0, 30));
                    xb = X_W'($urandom_range(LUT_DEPTH, 65535));
                end
                else if (pick >= 88 && pick < 93)
                begin
                    xa = X_W'($urandom_range(LUT_DEPTH - 1, 65535));
                    xb = X_W'($urandom_range(LUT_DEPTH - 1, 65535));
                end
                else if (pick >= 93 && pick < 97)
                    xb = X_W'($urandom_range(0, LUT_DEPTH - 1));
                else if (pick >= 97)
                begin
                    xa = X_W'($urandom);
                    xb = X_W'($urandom);
                end
                if ($urandom_range(0, 1) == 1)
                begin
                    tmp = xa;
                    xa  = xb;
                    xb  = tmp;
                end
                last_x = (xa < xb) ? xa : xb;
                queue_fill(xa, Y_W'($urandom), xb, Y_W'($urandom));
            end
            else if ($urandom_range(0, 1) == 1)
                queue_read(ADDR_W'(last_x + $urandom_range(0, 40)));
            else
                queue_read(ADDR_W'($urandom));
        end
        n_total = pending.size();

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || expected_beats.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);

        $display("covered %0d fills (%0d entries written, %0d writing nothing) and %0d reads",
                 fills_seen, cells_written, empty_fills, reads_seen);
        $display("with swapped, clipped and equal end points and a long output hold-off");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
